>>> hw/rtl/swpf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swpf_pkg: shared types and constants of the servo write packet framer
// Frame byte codes, byte positions, controller state, command and status
// structs, and the CRC-16 (poly 0x8005) byte fold.
// ----------------------------------------------------------------------------
package swpf_pkg;

  localparam logic [7:0]  HDR_SYNC     = 8'hFF;
  localparam logic [7:0]  HDR_MARK     = 8'hFD;
  localparam logic [7:0]  HDR_RSVD     = 8'h00;
  localparam logic [7:0]  INSTR_WRITE  = 8'h03;
  localparam logic [7:0]  LEN_OVERHEAD = 8'd5;
  localparam logic [15:0] CRC_POLY     = 16'h8005;

  localparam int CountW = 3;
  localparam int PosW   = 4;

  // fixed byte positions within the frame
  localparam logic [PosW-1:0] POS_SYNC0 = 4'd0;
  localparam logic [PosW-1:0] POS_SYNC1 = 4'd1;
  localparam logic [PosW-1:0] POS_MARK  = 4'd2;
  localparam logic [PosW-1:0] POS_RSVD  = 4'd3;
  localparam logic [PosW-1:0] POS_ID    = 4'd4;
  localparam logic [PosW-1:0] POS_LENL  = 4'd5;
  localparam logic [PosW-1:0] POS_LENH  = 4'd6;
  localparam logic [PosW-1:0] POS_INSTR = 4'd7;
  localparam logic [PosW-1:0] POS_ADRL  = 4'd8;
  localparam logic [PosW-1:0] POS_ADRH  = 4'd9;
  localparam logic [PosW-1:0] POS_DATA0 = 4'd10;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic advance;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
  } dp_status_t;

  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/swpf_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swpf_req_if: write request channel
// Valid/ready channel carrying one write request per word.
// ----------------------------------------------------------------------------
interface swpf_req_if;
  logic        valid;
  logic        ready;
  logic [7:0]  servo_id;
  logic [15:0] reg_address;
  logic [2:0]  data_length;
  logic [31:0] data_value;

  modport source (output valid, servo_id, reg_address, data_length, data_value,
                  input ready);
  modport sink   (input valid, servo_id, reg_address, data_length, data_value,
                  output ready);
endinterface
`default_nettype wire

>>> hw/rtl/swpf_frm_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swpf_frm_if: frame byte channel
// Valid/ready channel carrying one frame byte and its end flag per word.
// ----------------------------------------------------------------------------
interface swpf_frm_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_end;

  modport source (output valid, frame_byte, frame_end, input ready);
  modport sink   (input valid, frame_byte, frame_end, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/swpf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swpf_ctrl: framer controller
// Idle/emit state machine driving the handshakes and datapath commands.
// ----------------------------------------------------------------------------
module swpf_ctrl
  import swpf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output      logic       in_ready,
  output      logic       out_valid,
  input  wire logic       out_ready,
  output      dp_cmd_t    cmd,
  input  wire dp_status_t status
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    cmd.load    = 1'b0;
    cmd.advance = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.advance = 1'b1;
          // next request may enter as the last word leaves
          if (status.last) begin
            in_ready  = 1'b1;
            cmd.load  = in_valid;
            state_nxt = in_valid ? ST_EMIT : ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> hw/rtl/swpf_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swpf_dp: framer datapath
// Holds the request, the byte position and the running CRC; selects the
// current frame byte and folds every byte before the CRC into the CRC.
// ----------------------------------------------------------------------------
module swpf_dp
  import swpf_pkg::*;
#(
  parameter int MAX_DATA_BYTES = 4
)
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire dp_cmd_t     cmd,
  output      dp_status_t  status,
  input  wire logic [7:0]  servo_id,
  input  wire logic [15:0] reg_address,
  input  wire logic [2:0]  data_length,
  input  wire logic [31:0] data_value,
  output      logic [7:0]  frame_byte,
  output      logic        frame_end
);

  localparam logic [CountW-1:0] MaxCount = CountW'(MAX_DATA_BYTES);

  logic [7:0]        id_r;
  logic [15:0]       addr_r;
  logic [CountW-1:0] count_r;
  logic [31:0]       value_r;
  logic [15:0]       crc_r;
  logic [PosW-1:0]   pos_r;

  logic [CountW-1:0] count_in;
  logic [PosW-1:0]   off;
  logic              fold;

  always_comb begin
    if (data_length == '0) begin
      count_in = CountW'(1);
    end else if (data_length > MaxCount) begin
      count_in = MaxCount;
    end else begin
      count_in = data_length;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      id_r    <= servo_id;
      addr_r  <= reg_address;
      count_r <= count_in;
      value_r <= data_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= '0;
      pos_r <= '0;
    end else if (cmd.load) begin
      crc_r <= '0;
      pos_r <= '0;
    end else if (cmd.advance) begin
      if (fold) begin
        crc_r <= crc_fold(crc_r, frame_byte);
      end
      pos_r <= pos_r + PosW'(1);
    end
  end

  // offset past the address bytes: data, then crc low, then crc high
  assign off = pos_r - POS_DATA0;

  always_comb begin
    fold      = 1'b1;
    frame_end = 1'b0;
    unique case (pos_r)
      POS_SYNC0, POS_SYNC1: frame_byte = HDR_SYNC;
      POS_MARK:             frame_byte = HDR_MARK;
      POS_RSVD:             frame_byte = HDR_RSVD;
      POS_ID:               frame_byte = id_r;
      POS_LENL:             frame_byte = 8'(count_r) + LEN_OVERHEAD;
      POS_LENH:             frame_byte = 8'h00;
      POS_INSTR:            frame_byte = INSTR_WRITE;
      POS_ADRL:             frame_byte = addr_r[7:0];
      POS_ADRH:             frame_byte = addr_r[15:8];
      default: begin
        if (off < PosW'(count_r)) begin
          frame_byte = value_r[8*off[1:0] +: 8];
        end else if (off == PosW'(count_r)) begin
          fold       = 1'b0;
          frame_byte = crc_r[7:0];
        end else begin
          fold       = 1'b0;
          frame_end  = 1'b1;
          frame_byte = crc_r[15:8];
        end
      end
    endcase
  end

  assign status.last = frame_end;

endmodule
`default_nettype wire

>>> hw/rtl/servo_write_packet_framer_crc16.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// servo_write_packet_framer_crc16: servo bus write packet framer
// Turns one write request into a framed byte stream closed by a CRC-16.
// ----------------------------------------------------------------------------
//   channel   direction  words per request  payload
//   in_req    sink       1                  servo_id, reg_address, data_length,
//                                           data_value
//   out_frm   source     12 + n (n = 1..4)  frame_byte, frame_end
//
// One frame word leaves per cycle while out_frm is ready, stepped by the byte
// position counter in the datapath.
// A new request is taken in idle or in the cycle its predecessor's last word
// is taken. A stalled out_frm holds the current word and the CRC.
// Reset clears the state machine, position and CRC; no clearing pass.
// ----------------------------------------------------------------------------
module servo_write_packet_framer_crc16
  import swpf_pkg::*;
#(
  parameter int MAX_DATA_BYTES = 4
)
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  swpf_req_if.sink   in_req,
  swpf_frm_if.source out_frm
);

  dp_cmd_t    cmd;
  dp_status_t status;

  swpf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_frm.valid),
    .out_ready (out_frm.ready),
    .cmd       (cmd),
    .status    (status)
  );

  swpf_dp #(
    .MAX_DATA_BYTES (MAX_DATA_BYTES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .servo_id    (in_req.servo_id),
    .reg_address (in_req.reg_address),
    .data_length (in_req.data_length),
    .data_value  (in_req.data_value),
    .frame_byte  (out_frm.frame_byte),
    .frame_end   (out_frm.frame_end)
  );

endmodule
`default_nettype wire
